// File: hw/rtl/rsd_pkg.sv
`default_nettype none

package rsd_pkg;

	localparam int unsigned ANGLE_W = 8;
	localparam int unsigned DIST_W  = 10;
	localparam int unsigned SERVO_W = 10;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
	localparam logic [DIST_W-1:0]  DIGIT_SAT = 10'd999;
	localparam logic [DIST_W-1:0]  RANGE_MASK = 10'h3FF;

	// floor(y/45) = (y * SERVO_RECIP) >> SERVO_SHIFT, exact for y < 74898
	localparam logic [15:0] SERVO_RECIP = 16'd46604;
	localparam int unsigned SERVO_SHIFT = 21;

	typedef logic [6:0] seg_t;

	localparam seg_t SEG_0 = 7'h3F;
	localparam seg_t SEG_1 = 7'h06;
	localparam seg_t SEG_2 = 7'h5B;
	localparam seg_t SEG_3 = 7'h4F;
	localparam seg_t SEG_4 = 7'h66;
	localparam seg_t SEG_5 = 7'h6D;
	localparam seg_t SEG_6 = 7'h7D;
	localparam seg_t SEG_7 = 7'h07;
	localparam seg_t SEG_8 = 7'h7F;
	localparam seg_t SEG_9 = 7'h6F;

	// segment a in bit 0 ... segment g in bit 6, active high
	function automatic seg_t seg_encode(input logic [3:0] d);
		seg_t p;
		case (d)
			4'd0: p = SEG_0;
			4'd1: p = SEG_1;
			4'd2: p = SEG_2;
			4'd3: p = SEG_3;
			4'd4: p = SEG_4;
			4'd5: p = SEG_5;
			4'd6: p = SEG_6;
			4'd7: p = SEG_7;
			4'd8: p = SEG_8;
			4'd9: p = SEG_9;
			default: p = '0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/radar_sweep_display.sv
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// config   | sweep_step_we        | sweep_step_wdata[7:0]
// in       | in_valid / in_stall  | range_raw[9:0]
// out      | out_valid / out_stall| angle_shown, distance_shown,
//          |                      | display_low_word, display_high_word,
//          |                      | servo_position
//
// one request per cycle sustained while out_stall is low; an accepted request
// goes to out_valid through the input register, then the result register
// the sweep angle steps on each accepted input request, so the next request
// already sees the updated angle
// arst_n clears the sweep (0 degrees, upward), the step (1) and both valids
// in_stall rises only when both registers are full and out_stall is high

module radar_sweep_display
	import rsd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               sweep_step_we,
	input  wire logic [7:0]         sweep_step_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [DIST_W-1:0]  range_raw,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic      [ANGLE_W-1:0] angle_shown,
	output logic      [DIST_W-1:0]  distance_shown,
	output logic      [31:0]        display_low_word,
	output logic      [15:0]        display_high_word,
	output logic      [SERVO_W-1:0] servo_position
);

	// handshake
	logic in_accept;
	logic s2_free;
	logic s1_move;

	// angle state
	logic [ANGLE_W-1:0] angle_cur;
	logic [ANGLE_W-1:0] angle_nxt;

	// input register
	logic               valid_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic [ANGLE_W-1:0] angle_next_s1;
	logic [DIST_W-1:0]  dist_s1;

	// result register
	logic               valid_s2;
	logic [ANGLE_W-1:0] angle_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic [31:0]        low_s2;
	logic [15:0]        high_s2;
	logic [SERVO_W-1:0] servo_s2;

	// formatting between the two registers
	logic [23:0]        angle_pat;
	logic [23:0]        dist_pat;
	logic [SERVO_W-1:0] servo_pos;

	// result register frees when empty or taken this cycle
	assign s2_free   = !valid_s2 || !out_stall;
	assign s1_move   = valid_s1 && s2_free;
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;

	rsd_sweep u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_we    (sweep_step_we),
		.step_wdata (sweep_step_wdata),
		.advance    (in_accept),
		.angle      (angle_cur),
		.angle_next (angle_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			angle_s1      <= angle_cur;
			angle_next_s1 <= angle_nxt;
			dist_s1       <= range_raw & RANGE_MASK;
		end
	end

	// angle digits (0..180) and distance digits (saturated at 999)
	rsd_seg3 u_angle_seg (
		.value    ({{(DIST_W-ANGLE_W){1'b0}}, angle_s1}),
		.patterns (angle_pat)
	);

	rsd_seg3 u_dist_seg (
		.value    (dist_s1),
		.patterns (dist_pat)
	);

	// servo command follows the angle after the step
	rsd_servo u_servo (
		.angle    (angle_next_s1),
		.position (servo_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			angle_s2 <= angle_s1;
			dist_s2  <= dist_s1;
			low_s2   <= {dist_pat[7:0], angle_pat};
			high_s2  <= dist_pat[23:8];
			servo_s2 <= servo_pos;
		end
	end

	assign out_valid         = valid_s2;
	assign angle_shown       = angle_s2;
	assign distance_shown    = dist_s2;
	assign display_low_word  = low_s2;
	assign display_high_word = high_s2;
	assign servo_position    = servo_s2;

`ifndef SYNTHESIS
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle_cur <= ANGLE_MAX)
		else $error("sweep angle beyond end stop");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted request missing from input register");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_free |=> valid_s1 && $stable(dist_s1) && $stable(angle_s1))
		else $error("blocked input register lost its request");

	a_dist_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (distance_shown > DIGIT_SAT) |->
			(display_high_word[15:8] == {1'b0, SEG_9}) &&
			(display_low_word[31:24] == {1'b0, SEG_9}))
		else $error("distance above 999 not shown as 999");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/rsd_sweep.sv
`default_nettype none

module rsd_sweep
	import rsd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step_we,
	input  wire logic [7:0]         step_wdata,
	input  wire logic               advance,
	output logic      [ANGLE_W-1:0] angle,
	output logic      [ANGLE_W-1:0] angle_next
);

	logic [7:0]         step_q;
	logic [ANGLE_W-1:0] angle_q;
	logic               down_q;
	logic               down_next;
	logic [ANGLE_W:0]   sum;

	assign sum = {1'b0, angle_q} + {1'b0, step_q};

	always_comb begin
		if (!down_q) begin
			if (sum >= {1'b0, ANGLE_MAX}) begin
				angle_next = ANGLE_MAX;
				down_next  = 1'b1;
			end else begin
				angle_next = sum[ANGLE_W-1:0];
				down_next  = 1'b0;
			end
		end else begin
			if (angle_q <= step_q) begin
				angle_next = '0;
				down_next  = 1'b0;
			end else begin
				angle_next = angle_q - step_q;
				down_next  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= 8'd1;
			angle_q <= '0;
			down_q  <= 1'b0;
		end else begin
			if (step_we) begin
				step_q <= step_wdata;
			end
			if (advance) begin
				angle_q <= angle_next;
				down_q  <= down_next;
			end
		end
	end

	assign angle = angle_q;

endmodule

`default_nettype wire

// File: hw/rtl/rsd_seg3.sv
`default_nettype none

module rsd_seg3
	import rsd_pkg::*;
(
	input  wire logic [DIST_W-1:0] value,
	output logic      [23:0]       patterns
);

	logic [DIST_W-1:0] v;
	logic [3:0]        hund;
	logic [3:0]        tens;
	logic [3:0]        units;
	logic [6:0]        rem_h;
	logic [DIST_W-1:0] rem_w;

	assign v = (value > DIGIT_SAT) ? DIGIT_SAT : value;

	// parallel threshold compares instead of a divider
	always_comb begin
		hund = '0;
		for (int i = 1; i < 10; i++) begin
			if (v >= DIST_W'(i * 100)) begin
				hund = 4'(i);
			end
		end
	end

	assign rem_w = v - (DIST_W'(hund) * DIST_W'(100));
	assign rem_h = rem_w[6:0];

	always_comb begin
		tens = '0;
		for (int i = 1; i < 10; i++) begin
			if (rem_h >= 7'(i * 10)) begin
				tens = 4'(i);
			end
		end
	end

	assign units = 4'(rem_h - (7'(tens) * 7'd10));

	assign patterns = {1'b0, seg_encode(hund), 1'b0, seg_encode(tens),
		1'b0, seg_encode(units)};

endmodule

`default_nettype wire

// File: hw/rtl/rsd_servo.sv
`default_nettype none

module rsd_servo
	import rsd_pkg::*;
(
	input  wire logic [ANGLE_W-1:0] angle,
	output logic      [SERVO_W-1:0] position
);

	logic [17:0] scaled;
	logic [15:0] quarter;
	logic [31:0] prod;

	// angle*1023 = angle*1024 - angle, then /180 as (/4)/45
	assign scaled   = {angle, 10'b0} - {10'b0, angle};
	assign quarter  = scaled[17:2];
	assign prod     = {16'b0, quarter} * {16'b0, SERVO_RECIP};
	assign position = prod[SERVO_SHIFT +: SERVO_W];

endmodule

`default_nettype wire
